// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    // Operand format: signed fixed point
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Derived widths
    localparam int PW         = 2 * DATA_WIDTH;     // product width
    localparam int SW         = PW + 1;             // sum of products width
    localparam int NW         = SW + FRAC_BITS;     // scaled dividend width
    localparam int DIV_STAGES = DATA_WIDTH;         // one quotient bit per stage
    localparam int FRONT_STG  = 4;
    localparam int NUM_STG    = FRONT_STG + DIV_STAGES + 1;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_DIV0 = 2'd2;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});

    // Payload that travels down the pipeline
    typedef struct packed {
        logic [1:0]            op;
        logic                  div0;
        data_t                 res_re;
        data_t                 res_im;
        logic                  sat;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [PW-1:0]         den;
        logic [PW-1:0]         rem_re;
        logic [PW-1:0]         rem_im;
        logic [DATA_WIDTH-1:0] lq_re;
        logic [DATA_WIDTH-1:0] lq_im;
    } pipe_t;

    // Clamp a magnitude with sign to the data range: returns {sat, value}
    function automatic logic [DATA_WIDTH:0] sat_mag(input logic [SW-1:0] mag,
                                                    input logic neg);
        logic [SW-1:0]         lim;
        logic                  sat;
        logic [DATA_WIDTH-1:0] m;
        logic [DATA_WIDTH-1:0] v;
        lim = SW'(1) << (DATA_WIDTH - 1);
        if (!neg) begin
            lim = lim - SW'(1);
        end
        sat = (mag > lim);
        m   = sat ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        v   = neg ? (~m + DATA_WIDTH'(1)) : m;
        return {sat, v};
    endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Operand capture, add / subtract results, products, sums of products and scaling / overflow setup.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic                  aclk,
    input  logic [3:0]            en,
    input  logic [1:0]            s_op,
    input  cau_pkg::data_t        s_a_re,
    input  cau_pkg::data_t        s_a_im,
    input  cau_pkg::data_t        s_b_re,
    input  cau_pkg::data_t        s_b_im,
    output cau_pkg::pipe_t        p_out
);

    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PW;
    localparam int SW = cau_pkg::SW;
    localparam int NW = cau_pkg::NW;

    // Stage 1 registers
    logic [1:0]     op1_reg;
    cau_pkg::data_t ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // Stage 2 registers
    logic [1:0]            op2_reg;
    logic signed [PW-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_dd_reg;
    logic signed [PW-1:0]  p_rr_next, p_ii_next, p_ri_next, p_ir_next, p_bb_next, p_dd_next;
    cau_pkg::data_t        as_re2_reg, as_im2_reg;
    logic                  as_sat2_reg;
    logic signed [W:0]     as_re, as_im;
    logic [W:0]            as_mag_re, as_mag_im;
    logic [W:0]            as_sr, as_si;

    // Stage 3 registers
    logic [1:0]            op3_reg;
    logic signed [SW-1:0]  sum_re_reg, sum_im_reg, sum_re_next, sum_im_next;
    logic [PW-1:0]         den3_reg, den3_next;
    cau_pkg::data_t        as_re3_reg, as_im3_reg;
    logic                  as_sat3_reg;

    // Stage 4
    cau_pkg::pipe_t        p4_reg, p4_next;
    logic [SW-1:0]         mag_re, mag_im;
    logic [NW-1:0]         n_re, n_im, nhi_re, nhi_im;
    logic [W:0]            ms_re, ms_im;

    // Capture operands
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            op1_reg <= s_op;
            ar1_reg <= s_a_re;
            ai1_reg <= s_a_im;
            br1_reg <= s_b_re;
            bi1_reg <= s_b_im;
        end
    end

    // Form products and the add / subtract result
    always_comb begin
        p_rr_next = ar1_reg * br1_reg;
        p_ii_next = ai1_reg * bi1_reg;
        p_ri_next = ar1_reg * bi1_reg;
        p_ir_next = ai1_reg * br1_reg;
        p_bb_next = br1_reg * br1_reg;
        p_dd_next = bi1_reg * bi1_reg;
        if (op1_reg == cau_pkg::OP_SUB) begin
            as_re = (W+1)'(ar1_reg) - (W+1)'(br1_reg);
            as_im = (W+1)'(ai1_reg) - (W+1)'(bi1_reg);
        end else begin
            as_re = (W+1)'(ar1_reg) + (W+1)'(br1_reg);
            as_im = (W+1)'(ai1_reg) + (W+1)'(bi1_reg);
        end
        as_mag_re = as_re[W] ? (W+1)'(-as_re) : (W+1)'(as_re);
        as_mag_im = as_im[W] ? (W+1)'(-as_im) : (W+1)'(as_im);
        as_sr = cau_pkg::sat_mag(SW'(as_mag_re), as_re[W]);
        as_si = cau_pkg::sat_mag(SW'(as_mag_im), as_im[W]);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            op2_reg     <= op1_reg;
            p_rr_reg    <= p_rr_next;
            p_ii_reg    <= p_ii_next;
            p_ri_reg    <= p_ri_next;
            p_ir_reg    <= p_ir_next;
            p_bb_reg    <= p_bb_next;
            p_dd_reg    <= p_dd_next;
            as_re2_reg  <= as_sr[W-1:0];
            as_im2_reg  <= as_si[W-1:0];
            as_sat2_reg <= as_sr[W] | as_si[W];
        end
    end

    // Sum the products
    always_comb begin
        if (op2_reg == cau_pkg::OP_MUL) begin
            sum_re_next = SW'(p_rr_reg) - SW'(p_ii_reg);
            sum_im_next = SW'(p_ri_reg) + SW'(p_ir_reg);
        end else begin
            sum_re_next = SW'(p_rr_reg) + SW'(p_ii_reg);
            sum_im_next = SW'(p_ir_reg) - SW'(p_ri_reg);
        end
        den3_next = $unsigned(p_bb_reg) + $unsigned(p_dd_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            op3_reg     <= op2_reg;
            sum_re_reg  <= sum_re_next;
            sum_im_reg  <= sum_im_next;
            den3_reg    <= den3_next;
            as_re3_reg  <= as_re2_reg;
            as_im3_reg  <= as_im2_reg;
            as_sat3_reg <= as_sat2_reg;
        end
    end

    // Scale products back, set up the division
    always_comb begin
        mag_re = sum_re_reg[SW-1] ? SW'(-sum_re_reg) : SW'(sum_re_reg);
        mag_im = sum_im_reg[SW-1] ? SW'(-sum_im_reg) : SW'(sum_im_reg);
        ms_re  = cau_pkg::sat_mag(mag_re >> cau_pkg::FRAC_BITS, sum_re_reg[SW-1]);
        ms_im  = cau_pkg::sat_mag(mag_im >> cau_pkg::FRAC_BITS, sum_im_reg[SW-1]);
        n_re   = NW'(mag_re) << cau_pkg::FRAC_BITS;
        n_im   = NW'(mag_im) << cau_pkg::FRAC_BITS;
        nhi_re = n_re >> W;
        nhi_im = n_im >> W;

        p4_next        = '0;
        p4_next.op     = op3_reg;
        p4_next.div0   = (den3_reg == '0);
        p4_next.neg_re = sum_re_reg[SW-1];
        p4_next.neg_im = sum_im_reg[SW-1];
        p4_next.ovf_re = (nhi_re >= NW'(den3_reg));
        p4_next.ovf_im = (nhi_im >= NW'(den3_reg));
        p4_next.den    = den3_reg;
        p4_next.rem_re = nhi_re[PW-1:0];
        p4_next.rem_im = nhi_im[PW-1:0];
        p4_next.lq_re  = n_re[W-1:0];
        p4_next.lq_im  = n_im[W-1:0];
        if (op3_reg == cau_pkg::OP_MUL) begin
            p4_next.res_re = ms_re[W-1:0];
            p4_next.res_im = ms_im[W-1:0];
            p4_next.sat    = ms_re[W] | ms_im[W];
        end else begin
            p4_next.res_re = as_re3_reg;
            p4_next.res_im = as_im3_reg;
            p4_next.sat    = as_sat3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            p4_reg <= p4_next;
        end
    end

    assign p_out = p4_reg;

endmodule

// ===== hw/rtl/cau_div_step.sv =====
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring division stage: one quotient bit for each component.
// ----------------------------------------------------------------------------
module cau_div_step (
    input  logic           aclk,
    input  logic           en,
    input  cau_pkg::pipe_t d_in,
    output cau_pkg::pipe_t d_out
);

    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PW;

    cau_pkg::pipe_t d_reg, d_next;
    logic [PW:0]    t_re, t_im;
    logic [PW+1:0]  diff_re, diff_im;
    logic           ge_re, ge_im;

    // Shift in the next dividend bit, trial subtract the divisor
    always_comb begin
        t_re    = {d_in.rem_re, d_in.lq_re[W-1]};
        t_im    = {d_in.rem_im, d_in.lq_im[W-1]};
        diff_re = {1'b0, t_re} - {2'b00, d_in.den};
        diff_im = {1'b0, t_im} - {2'b00, d_in.den};
        ge_re   = ~diff_re[PW+1];
        ge_im   = ~diff_im[PW+1];

        d_next        = d_in;
        d_next.rem_re = ge_re ? diff_re[PW-1:0] : t_re[PW-1:0];
        d_next.rem_im = ge_im ? diff_im[PW-1:0] : t_im[PW-1:0];
        d_next.lq_re  = {d_in.lq_re[W-2:0], ge_re};
        d_next.lq_im  = {d_in.lq_im[W-2:0], ge_im};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// ----------------------------------------------------------------------------
// The unit takes one beat per cycle while the pipe has room or the result is
// taken, and returns one result beat per input beat, in order. The path has
// DATA_WIDTH + 5 register stages (37 at the default 32-bit width). The depth
// is set by the restoring divider, which produces one quotient bit per
// pipeline stage; every operation travels the same path.
// Each stage moves forward whenever it or a later stage has a bubble or the
// result is taken, so the input stays ready while a result waits and the
// pipe has room.
module complex_arithmetic_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_op,
    input  cau_pkg::data_t s_a_re,
    input  cau_pkg::data_t s_a_im,
    input  cau_pkg::data_t s_b_re,
    input  cau_pkg::data_t s_b_im,
    output logic           m_valid,
    input  logic           m_ready,
    output cau_pkg::data_t m_res_re,
    output cau_pkg::data_t m_res_im,
    output logic [1:0]     m_status
);

    localparam int W   = cau_pkg::DATA_WIDTH;
    localparam int SW  = cau_pkg::SW;
    localparam int NST = cau_pkg::NUM_STG;
    localparam int FS  = cau_pkg::FRONT_STG;
    localparam int DS  = cau_pkg::DIV_STAGES;

    logic [NST-1:0]  vld_reg;
    logic [NST-1:0]  en;
    cau_pkg::pipe_t  stg [0:DS];

    cau_pkg::data_t  res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic [1:0]      status_reg, status_next;
    logic [W:0]      qs_re, qs_im;
    logic            qsat_re, qsat_im;

    // Advance a stage when the result is taken or it or a later stage is empty
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = m_ready | ~(&vld_reg[NST-1:k]);
    end

    // Move valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= (k == 0) ? s_valid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NST-1];

    cau_front u_front (
        .aclk   (aclk),
        .en     (en[FS-1:0]),
        .s_op   (s_op),
        .s_a_re (s_a_re),
        .s_a_im (s_a_im),
        .s_b_re (s_b_re),
        .s_b_im (s_b_im),
        .p_out  (stg[0])
    );

    for (genvar i = 0; i < DS; i++) begin : g_div
        cau_div_step u_step (
            .aclk  (aclk),
            .en    (en[FS+i]),
            .d_in  (stg[i]),
            .d_out (stg[i+1])
        );
    end

    // Saturate quotients and select the result
    always_comb begin
        qs_re   = cau_pkg::sat_mag(SW'(stg[DS].lq_re), stg[DS].neg_re);
        qs_im   = cau_pkg::sat_mag(SW'(stg[DS].lq_im), stg[DS].neg_im);
        qsat_re = stg[DS].ovf_re | qs_re[W];
        qsat_im = stg[DS].ovf_im | qs_im[W];
        if (stg[DS].op == cau_pkg::OP_DIV) begin
            if (stg[DS].div0) begin
                res_re_next = '0;
                res_im_next = '0;
                status_next = cau_pkg::STAT_DIV0;
            end else begin
                res_re_next = stg[DS].ovf_re ?
                              (stg[DS].neg_re ? cau_pkg::DATA_MIN : cau_pkg::DATA_MAX) :
                              qs_re[W-1:0];
                res_im_next = stg[DS].ovf_im ?
                              (stg[DS].neg_im ? cau_pkg::DATA_MIN : cau_pkg::DATA_MAX) :
                              qs_im[W-1:0];
                status_next = (qsat_re | qsat_im) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
            end
        end else begin
            res_re_next = stg[DS].res_re;
            res_im_next = stg[DS].res_im;
            status_next = stg[DS].sat ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
        end
    end

    // Hold the result beat
    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    assign m_res_re = res_re_reg;
    assign m_res_im = res_im_reg;
    assign m_status = status_reg;

`ifndef NO_ASSERTIONS
    a_reset_empty : assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_div0_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == cau_pkg::STAT_DIV0) |-> (m_res_re == '0 && m_res_im == '0))
        else $error("division by zero result not zero");

    a_sat_clamped : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == cau_pkg::STAT_SAT) |->
        (m_res_re == cau_pkg::DATA_MAX || m_res_re == cau_pkg::DATA_MIN ||
         m_res_im == cau_pkg::DATA_MAX || m_res_im == cau_pkg::DATA_MIN))
        else $error("saturated status without a clamped component");

    a_full_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        ((&vld_reg) && !m_ready) |-> !s_ready)
        else $error("input accepted into a full stalled pipeline");

    a_accept_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted beat not in first stage");
`endif

endmodule
